// ----- src/ndt_pkg.sv -----
// ----------------------------------------------------------------------------
// Note duration tracker package
// Field widths, item codes, sequencer states and status types shared by the
// note duration tracker, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package ndt_pkg;

  // Payload field widths of the input and result items.
  localparam int KIND_W     = 2;
  localparam int NOTE_W     = 7;
  localparam int DUR_W      = 32;
  localparam int EL_W       = 32;
  localparam int MASK_W     = 64;
  localparam int WAIT_W     = 32;
  // Both banks together and the index into them.
  localparam int MASK_ALL_W = 2 * MASK_W;
  localparam int MASK_IDX_W = 7;

  // Input item kinds. The fourth code carries no meaning and is dropped.
  localparam logic [KIND_W-1:0] KIND_PLAY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SLEEP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TIME  = 2'd2;

  // Result item kinds.
  localparam logic RK_PLAY   = 1'b0;
  localparam logic RK_EXPIRY = 1'b1;

  // Bank numbers.
  localparam logic BANK_LOW  = 1'b0;
  localparam logic BANK_HIGH = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_PLAY_RD = 8'b0000_0010,
    ST_PLAY_WR = 8'b0000_0100,
    ST_SLEEP   = 8'b0000_1000,
    ST_SWEEP   = 8'b0001_0000,
    ST_RES_PLY = 8'b0010_0000,
    ST_RES_B0  = 8'b0100_0000,
    ST_RES_B1  = 8'b1000_0000
  } state_e;

  // Status flags from the shared countdown unit.
  typedef struct packed {
    logic expired;  // an active countdown just reached zero
    logic any;      // some countdown seen so far is still pending
  } alu_flags_t;

endpackage

// ----- src/ndt_if.sv -----
// ----------------------------------------------------------------------------
// Note duration tracker channels
// Valid/ready channels for input items and result items of the tracker.
// ----------------------------------------------------------------------------
interface ndt_in_if;
  import ndt_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [NOTE_W-1:0] note;
  logic [DUR_W-1:0]  duration;
  logic [EL_W-1:0]   elapsed;

  modport source (output valid, kind, note, duration, elapsed, input ready);
  modport sink   (input valid, kind, note, duration, elapsed, output ready);
endinterface

interface ndt_out_if;
  import ndt_pkg::*;

  logic              valid;
  logic              ready;
  logic              report_kind;
  logic [NOTE_W-1:0] played_note;
  logic              note_on_sent;
  logic              bank;
  logic [MASK_W-1:0] expired_mask;
  logic [WAIT_W-1:0] next_wait;
  logic              wait_valid;
  logic              last;

  modport source (output valid, report_kind, played_note, note_on_sent, bank,
                  expired_mask, next_wait, wait_valid, last, input ready);
  modport sink   (input valid, report_kind, played_note, note_on_sent, bank,
                  expired_mask, next_wait, wait_valid, last, output ready);
endinterface

// ----- src/ndt_ram.sv -----
// ----------------------------------------------------------------------------
// Note countdown memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ndt_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/ndt_alu.sv -----
// ----------------------------------------------------------------------------
// Shared countdown unit
// Saturating subtract of the elapsed time from one countdown, expiry test
// and running minimum of the countdowns that stay pending.
// ----------------------------------------------------------------------------
module ndt_alu #(
  parameter int TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0]    value_i,
  input  logic                    active_i,
  input  logic [ndt_pkg::EL_W-1:0] elapsed_i,
  input  logic [TIME_BITS-1:0]    best_i,
  input  logic                    best_any_i,
  output logic [TIME_BITS-1:0]    result_o,
  output logic [TIME_BITS-1:0]    best_o,
  output ndt_pkg::alu_flags_t     flags_o
);
  import ndt_pkg::*;

  localparam int WIDE = (TIME_BITS > EL_W) ? TIME_BITS : EL_W;

  logic [WIDE-1:0] value_w;
  logic [WIDE-1:0] el_w;
  logic [WIDE-1:0] diff_w;
  logic            live;
  logic            take;

  // Saturating subtract in a width that holds both operands.
  always_comb begin
    value_w  = WIDE'(value_i);
    el_w     = WIDE'(elapsed_i);
    diff_w   = (value_w > el_w) ? (value_w - el_w) : '0;
    result_o = active_i ? diff_w[TIME_BITS-1:0] : '0;
  end

  // Expiry and running minimum of nonzero countdowns.
  always_comb begin
    live            = (result_o != '0);
    take            = live && (!best_any_i || (result_o < best_i));
    best_o          = take ? result_o : best_i;
    flags_o.expired = active_i && !live;
    flags_o.any     = best_any_i || live;
  end

endmodule

// ----- src/note_duration_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// Note duration tracker
// Keeps a countdown per note and a sleep countdown, reports note-ons for play
// items and note-off masks plus the smallest pending wait for time items.
// ----------------------------------------------------------------------------
// Usage: input items arrive on in_i, result items leave on out_o, both
// valid/ready. The block takes one item at a time; in_i.ready is high only
// while it is idle.
// A sleep item (and the unused kind code) is taken with no result; the block stays idle.
// A play item yields its single result after these steps: read
// and update of the note, one pass of the sleep countdown, then a sweep of
// the note memory for the smallest pending wait.
// A time item passes the sleep countdown and the sweep before its two results (bank 0,
// then bank 1 with last set).
// The rate is set by the sweep: the note memory has one read port, and the
// one shared subtract/compare unit handles one note per cycle.
// Reset clears the per-note active bits and the sleep countdown at once; no
// clearing pass runs. A stalled receiver holds the result on out_o and the
// block stays busy until the last result of the item is taken.
// ----------------------------------------------------------------------------
module note_duration_tracker_unit #(
  parameter int NOTE_COUNT = 128,
  parameter int TIME_BITS  = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  ndt_in_if.sink    in_i,
  ndt_out_if.source out_o
);
  import ndt_pkg::*;

  localparam int                 NOTE_AW    = $clog2(NOTE_COUNT);
  localparam int                 WIDE       = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
  localparam logic [NOTE_AW:0]   CNT_END    = (NOTE_AW + 1)'(NOTE_COUNT);
  localparam logic [NOTE_W:0]    NOTE_LIMIT = (NOTE_W + 1)'(NOTE_COUNT);
  localparam logic [WIDE-1:0]    TIME_MAX_W = WIDE'({TIME_BITS{1'b1}});

  state_e                  state_q, state_d;
  logic [NOTE_COUNT-1:0]   active_q;
  logic [TIME_BITS-1:0]    sleep_q;
  logic [NOTE_AW:0]        cnt_q;
  logic                    p_valid_q;
  logic [NOTE_AW-1:0]      p_idx_q;
  logic                    play_q;

  logic [NOTE_W-1:0]       note_q;
  logic [TIME_BITS-1:0]    dur_q;
  logic [EL_W-1:0]         el_q;
  logic                    on_q;
  logic [TIME_BITS-1:0]    best_q;
  logic                    any_q;
  logic [MASK_ALL_W-1:0]   mask_q;

  logic                    in_acc;
  logic                    out_acc;
  logic [WIDE-1:0]         dur_wide;
  logic [TIME_BITS-1:0]    dur_sat;
  logic                    note_in_range;
  logic [NOTE_AW-1:0]      note_addr;
  logic                    note_active;
  logic [TIME_BITS-1:0]    stored;
  logic                    play_write;
  logic                    sweep_write;
  logic                    sweep_issue;

  logic                    ram_we;
  logic [NOTE_AW-1:0]      ram_waddr;
  logic [TIME_BITS-1:0]    ram_wdata;
  logic                    ram_re;
  logic [NOTE_AW-1:0]      ram_raddr;
  logic [TIME_BITS-1:0]    ram_rdata;

  logic [TIME_BITS-1:0]    alu_value;
  logic                    alu_active;
  logic [TIME_BITS-1:0]    alu_best_in;
  logic                    alu_any_in;
  logic [TIME_BITS-1:0]    alu_result;
  logic [TIME_BITS-1:0]    alu_best;
  alu_flags_t              alu_flags;

  logic [WIDE-1:0]         best_wide;
  logic [WAIT_W-1:0]       wait_sat;

  // Handshakes.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;

  // A duration beyond the countdown range saturates.
  always_comb begin
    dur_wide = WIDE'(in_i.duration);
    dur_sat  = (dur_wide > TIME_MAX_W) ? TIME_MAX_W[TIME_BITS-1:0]
                                       : dur_wide[TIME_BITS-1:0];
  end

  // Play lookup: an inactive note reads as zero.
  always_comb begin
    note_in_range = ({1'b0, note_q} < NOTE_LIMIT);
    note_addr     = note_q[NOTE_AW-1:0];
    note_active   = note_in_range && active_q[note_addr];
    stored        = note_active ? ram_rdata : '0;
    play_write    = (state_q == ST_PLAY_WR) && note_in_range && (stored < dur_q);
    sweep_issue   = (state_q == ST_SWEEP) && (cnt_q != CNT_END);
    sweep_write   = (state_q == ST_SWEEP) && p_valid_q && active_q[p_idx_q];
  end

  // Memory port control.
  always_comb begin
    ram_we    = play_write || sweep_write;
    ram_waddr = play_write ? note_addr : p_idx_q;
    ram_wdata = play_write ? dur_q : alu_result;
    ram_re    = (state_q == ST_PLAY_RD) || sweep_issue;
    ram_raddr = (state_q == ST_PLAY_RD) ? note_addr : cnt_q[NOTE_AW-1:0];
  end

  ndt_ram #(
    .DEPTH (NOTE_COUNT),
    .WIDTH (TIME_BITS)
  ) u_ndt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared unit operands: the sleep countdown first, then one note per cycle.
  always_comb begin
    if (state_q == ST_SLEEP) begin
      alu_value   = sleep_q;
      alu_active  = 1'b1;
      alu_best_in = '0;
      alu_any_in  = 1'b0;
    end else begin
      alu_value   = ram_rdata;
      alu_active  = active_q[p_idx_q];
      alu_best_in = best_q;
      alu_any_in  = any_q;
    end
  end

  ndt_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_ndt_alu (
    .value_i    (alu_value),
    .active_i   (alu_active),
    .elapsed_i  (el_q),
    .best_i     (alu_best_in),
    .best_any_i (alu_any_in),
    .result_o   (alu_result),
    .best_o     (alu_best),
    .flags_o    (alu_flags)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.kind)
            KIND_PLAY: state_d = ST_PLAY_RD;
            KIND_TIME: state_d = ST_SLEEP;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_PLAY_RD: state_d = ST_PLAY_WR;
      ST_PLAY_WR: state_d = ST_SLEEP;
      ST_SLEEP:   state_d = ST_SWEEP;
      ST_SWEEP: begin
        if (cnt_q == CNT_END) begin
          state_d = play_q ? ST_RES_PLY : ST_RES_B0;
        end
      end
      ST_RES_PLY: begin
        if (out_acc) state_d = ST_IDLE;
      end
      ST_RES_B0: begin
        if (out_acc) state_d = ST_RES_B1;
      end
      ST_RES_B1: begin
        if (out_acc) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, active bits and the sleep countdown.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      active_q  <= '0;
      sleep_q   <= '0;
      cnt_q     <= '0;
      p_valid_q <= 1'b0;
      p_idx_q   <= '0;
      play_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        play_q <= (in_i.kind == KIND_PLAY);
        if (in_i.kind == KIND_SLEEP) begin
          sleep_q <= dur_sat;
        end
      end
      if (play_write) begin
        active_q[note_addr] <= 1'b1;
      end
      if (state_q == ST_SLEEP) begin
        sleep_q   <= alu_result;
        cnt_q     <= '0;
        p_valid_q <= 1'b0;
      end
      if (state_q == ST_SWEEP) begin
        p_valid_q <= sweep_issue;
        if (sweep_issue) begin
          cnt_q   <= cnt_q + 1'b1;
          p_idx_q <= cnt_q[NOTE_AW-1:0];
        end
        if (p_valid_q && alu_flags.expired) begin
          active_q[p_idx_q] <= 1'b0;
        end
      end
    end
  end

  // Item fields, running minimum and expiry masks.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      note_q <= in_i.note;
      dur_q  <= dur_sat;
      el_q   <= (in_i.kind == KIND_TIME) ? in_i.elapsed : '0;
      mask_q <= '0;
    end
    if (state_q == ST_PLAY_WR) begin
      on_q <= note_in_range && !note_active;
    end
    if (state_q == ST_SLEEP) begin
      best_q <= alu_best;
      any_q  <= alu_flags.any;
    end
    if ((state_q == ST_SWEEP) && p_valid_q) begin
      best_q <= alu_best;
      any_q  <= alu_flags.any;
      if (alu_flags.expired) begin
        mask_q[MASK_IDX_W'(p_idx_q)] <= 1'b1;
      end
    end
  end

  // Smallest wait saturated to the result width.
  always_comb begin
    best_wide = WIDE'(best_q);
    wait_sat  = ((best_wide >> WAIT_W) != '0) ? '1 : best_wide[WAIT_W-1:0];
  end

  // Result item drive.
  always_comb begin
    out_o.valid        = (state_q == ST_RES_PLY) || (state_q == ST_RES_B0) ||
                         (state_q == ST_RES_B1);
    out_o.report_kind  = (state_q == ST_RES_PLY) ? RK_PLAY : RK_EXPIRY;
    out_o.played_note  = (state_q == ST_RES_PLY) ? note_q : '0;
    out_o.note_on_sent = (state_q == ST_RES_PLY) && on_q;
    out_o.bank         = (state_q == ST_RES_B1) ? BANK_HIGH : BANK_LOW;
    out_o.expired_mask = '0;
    if (state_q == ST_RES_B0) out_o.expired_mask = mask_q[MASK_W-1:0];
    if (state_q == ST_RES_B1) out_o.expired_mask = mask_q[MASK_ALL_W-1:MASK_W];
    out_o.next_wait    = (state_q == ST_RES_B0) ? '0 : wait_sat;
    out_o.wait_valid   = (state_q != ST_RES_B0) && any_q;
    out_o.last         = (state_q != ST_RES_B0);
  end

endmodule

// ----- src/ndt_checker.sv -----
// ----------------------------------------------------------------------------
// Note duration tracker checker
// Port-level properties of the tracker's item sequencing, bound to the top.
// ----------------------------------------------------------------------------
module ndt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [ndt_pkg::KIND_W-1:0] in_kind_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_bank_i,
  input logic                       out_last_i
);
  import ndt_pkg::*;

  // The block never offers a result while it takes a new item.
  a_busy_or_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !out_valid_i)
    else $error("ready for an item while a result is offered");

  // A waiting result is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  // Items without results leave the block idle at once.
  a_no_result_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_kind_i != KIND_PLAY) && (in_kind_i != KIND_TIME)
    |=> in_ready_i)
    else $error("item without results kept the block busy");

  // The bank 1 report directly follows the bank 0 report.
  a_bank_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && out_bank_i && out_last_i)
    else $error("bank 1 report did not follow bank 0");

  // After the last result the block is ready again.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> in_ready_i)
    else $error("block not ready after its last result");

endmodule

bind note_duration_tracker_unit ndt_checker u_ndt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_bank_i  (out_o.bank),
  .out_last_i  (out_o.last)
);

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Note duration tracker testbench
// Drives play, sleep, elapsed-time and unused-kind items into the tracker
// under several sender and receiver idling patterns. A behavioral copy of the
// countdown state predicts every result item, and a checker compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ndt_pkg::*;

  localparam int NOTE_COUNT  = 128;
  localparam int TIME_BITS   = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 312;
  localparam int MAX_PRINTS  = 40;

  // One expected result item.
  typedef struct {
    logic              report_kind;
    logic [NOTE_W-1:0] played_note;
    logic              note_on_sent;
    logic              bank;
    logic [MASK_W-1:0] expired_mask;
    logic [WAIT_W-1:0] next_wait;
    logic              wait_valid;
    logic              last;
  } report_t;

  logic clk_i;
  logic rst_ni;

  ndt_in_if  in_if ();
  ndt_out_if out_if ();

  note_duration_tracker_unit #(
    .NOTE_COUNT(NOTE_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Predicted countdowns and the results still owed by the block.
  logic [TIME_BITS-1:0] note_left [NOTE_COUNT];
  logic [TIME_BITS-1:0] sleep_left;
  report_t              expected_reports [$];

  int error_count;
  int cycle_count;
  int send_idle_pct;
  int stall_pct;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Cycle counter with a hard stop in case the block hangs.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Prints one mismatch line, up to a cap, and counts every one.
  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  // Smallest nonzero countdown among the notes and the sleep timer.
  function automatic void find_soonest(output logic [WAIT_W-1:0] soonest,
                                       output logic pending);
    logic [TIME_BITS-1:0] best;
    best    = sleep_left;
    pending = (sleep_left != '0);
    for (int i = 0; i < NOTE_COUNT; i++) begin
      if (note_left[i] != '0 && (!pending || note_left[i] < best)) begin
        best    = note_left[i];
        pending = 1'b1;
      end
    end
    soonest = best;
  endfunction

  // Updates the predicted countdowns for one accepted item and queues the
  // result items it should cause.
  task automatic track_item(input logic [KIND_W-1:0] kind,
                            input logic [NOTE_W-1:0] note,
                            input logic [DUR_W-1:0] dur,
                            input logic [EL_W-1:0] el);
    report_t              r;
    logic [MASK_ALL_W-1:0] gone;
    r    = '{default: '0};
    gone = '0;
    case (kind)
      KIND_PLAY: begin
        r.report_kind = RK_PLAY;
        r.played_note = note;
        if (note < NOTE_COUNT) begin
          r.note_on_sent = (note_left[note] == '0);
          if (note_left[note] < dur) note_left[note] = dur;
        end
        find_soonest(r.next_wait, r.wait_valid);
        r.last = 1'b1;
        expected_reports.push_back(r);
      end
      KIND_SLEEP: begin
        sleep_left = dur;
      end
      KIND_TIME: begin
        // Saturating countdown; a note that lands on zero is a note-off.
        for (int i = 0; i < NOTE_COUNT; i++) begin
          if (note_left[i] != '0) begin
            note_left[i] = (note_left[i] > el) ? note_left[i] - el : '0;
            if (note_left[i] == '0) gone[i] = 1'b1;
          end
        end
        sleep_left = (sleep_left > el) ? sleep_left - el : '0;
        r.report_kind  = RK_EXPIRY;
        r.bank         = BANK_LOW;
        r.expired_mask = gone[MASK_W-1:0];
        expected_reports.push_back(r);
        r.bank         = BANK_HIGH;
        r.expired_mask = gone[MASK_ALL_W-1:MASK_W];
        find_soonest(r.next_wait, r.wait_valid);
        r.last         = 1'b1;
        expected_reports.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Presents one item, after a random idle gap, and waits for its acceptance.
  // The valid stays high afterwards so back-to-back items follow without a gap.
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [NOTE_W-1:0] note,
                           input logic [DUR_W-1:0] dur,
                           input logic [EL_W-1:0] el);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.kind     <= kind;
    in_if.note     <= note;
    in_if.duration <= dur;
    in_if.elapsed  <= el;
    do @(posedge clk_i); while (!in_if.ready);
    track_item(kind, note, dur, el);
  endtask

  // Holds the sender back until every owed result has arrived.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_reports.size() != 0);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_reports.size() == 0) begin
        report_error("result item with no expectation waiting");
      end else begin
        want = expected_reports.pop_front();
        check_field("report_kind", 64'(out_if.report_kind), 64'(want.report_kind));
        check_field("played_note", 64'(out_if.played_note), 64'(want.played_note));
        check_field("note_on_sent", 64'(out_if.note_on_sent),
                    64'(want.note_on_sent));
        check_field("bank", 64'(out_if.bank), 64'(want.bank));
        check_field("expired_mask", out_if.expired_mask, want.expired_mask);
        check_field("next_wait", 64'(out_if.next_wait), 64'(want.next_wait));
        check_field("wait_valid", 64'(out_if.wait_valid), 64'(want.wait_valid));
        check_field("last", 64'(out_if.last), 64'(want.last));
      end
    end
  end

  // Receiver with random back-pressure.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // A time value: mostly short so that notes expire often, some zero, some
  // across the whole 32-bit range.
  function automatic logic [31:0] pick_time(input int short_max);
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 25) return $urandom;
    return $urandom_range(short_max, 1);
  endfunction

  // Plays: note-on on idle notes, repeats that keep or raise the countdown,
  // zero-length plays, the extreme notes and durations.
  task automatic test_play_basics();
    send_item(KIND_TIME, NOTE_W'($urandom), $urandom, 32'd0);
    send_item(KIND_PLAY, 7'd0, 32'd0, $urandom);
    send_item(KIND_PLAY, 7'd0, 32'd1000, $urandom);
    send_item(KIND_PLAY, 7'd0, 32'd500, $urandom);
    send_item(KIND_PLAY, 7'd0, 32'd2000, $urandom);
    send_item(KIND_PLAY, 7'd127, 32'hFFFF_FFFF, $urandom);
    send_item(KIND_PLAY, 7'd63, 32'd1, $urandom);
    send_item(KIND_PLAY, 7'd64, 32'd1, $urandom);
    send_item(KIND_PLAY, 7'h55, 32'h5555_5555, $urandom);
    send_item(KIND_PLAY, 7'h2A, 32'hAAAA_AAAA, $urandom);
  endtask

  // Sleep loads, zero and exact elapsed times, and a full saturating sweep.
  task automatic test_sleep_and_time();
    send_item(KIND_SLEEP, NOTE_W'($urandom), 32'd300, $urandom);
    send_item(KIND_TIME, NOTE_W'($urandom), $urandom, 32'd0);
    send_item(KIND_TIME, NOTE_W'($urandom), $urandom, 32'd1);
    send_item(KIND_TIME, NOTE_W'($urandom), $urandom, 32'd299);
    send_item(KIND_PLAY, 7'd5, 32'd10, $urandom);
    send_item(KIND_TIME, NOTE_W'($urandom), $urandom, 32'd10);
    send_item(KIND_PLAY, 7'd5, 32'd7, $urandom);
    send_item(KIND_SLEEP, NOTE_W'($urandom), 32'hFFFF_FFFF, $urandom);
    send_item(KIND_TIME, NOTE_W'($urandom), $urandom, 32'h5555_5555);
    send_item(KIND_TIME, NOTE_W'($urandom), $urandom, 32'hAAAA_AAAA);
    send_item(KIND_TIME, NOTE_W'($urandom), $urandom, 32'hFFFF_FFFF);
    send_item(KIND_SLEEP, NOTE_W'($urandom), 32'd0, $urandom);
    send_item(KIND_TIME, NOTE_W'($urandom), $urandom, 32'd5);
  endtask

  // The unused kind code must be swallowed without a result.
  task automatic test_unused_kind();
    logic [KIND_W-1:0] unused_kind;
    unused_kind = ~KIND_PLAY;
    send_item(unused_kind, NOTE_W'($urandom), $urandom, $urandom);
    send_item(KIND_PLAY, 7'd9, 32'd40, $urandom);
    send_item(unused_kind, NOTE_W'($urandom), $urandom, $urandom);
    send_item(KIND_TIME, NOTE_W'($urandom), $urandom, 32'd40);
  endtask

  // Random traffic under one idling pattern. Half the plays hit a small set
  // of notes so that repeats and raises happen often.
  task automatic test_random_traffic(input int idle_pct, input int stall);
    int                r;
    int                sent;
    logic [NOTE_W-1:0] note;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    sent          = 0;
    while (sent < PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 45) begin
        note = ($urandom_range(1) == 0) ? NOTE_W'($urandom_range(15))
                                        : NOTE_W'($urandom_range(127));
        send_item(KIND_PLAY, note, pick_time(3000), $urandom);
        sent++;
      end else if (r < 58) begin
        send_item(KIND_SLEEP, NOTE_W'($urandom), pick_time(3000), $urandom);
        sent++;
      end else if (r < 96) begin
        send_item(KIND_TIME, NOTE_W'($urandom), $urandom, pick_time(1500));
        sent++;
      end else begin
        send_item(~KIND_PLAY, NOTE_W'($urandom), $urandom, $urandom);
      end
    end
  endtask

  // Stimulus sequence.
  initial begin
    error_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int i = 0; i < NOTE_COUNT; i++) note_left[i] = '0;
    sleep_left = '0;

    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.kind     <= KIND_PLAY;
    in_if.note     <= '0;
    in_if.duration <= '0;
    in_if.elapsed  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_play_basics();
    test_sleep_and_time();
    test_unused_kind();
    drain_results();
    test_random_traffic(0, 0);
    drain_results();
    test_random_traffic(50, 0);
    test_random_traffic(0, 50);
    drain_results();
    test_random_traffic(15, 15);

    // Let every owed result arrive, then watch for stray ones.
    drain_results();
    repeat (2 * NOTE_COUNT + 16) @(posedge clk_i);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
